@@ sv/bpd_pkg.sv @@
// Shared types, register indexes and the border decision for the 3x3 border pixel detector.
package bpd_pkg;

  localparam int PIXEL_W   = 32;
  localparam int COORD_W   = 10;
  localparam int SIZE_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LINE_W    = 2;   // {two rows above, row above}
  localparam int WIN_W     = 9;   // three columns of three row flags

  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 2'd2;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               frame_start;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_of_run;
  } point_t;

  // Position of the newest pixel against the image edges.
  typedef struct packed {
    logic col_first;   // cx == 0
    logic col_second;  // cx == 1
    logic col_last;    // cx == W-1
    logic row_first;   // cy == 0
    logic row_second;  // cy == 1
    logic row_last;    // cy == H-1
  } pos_flags_t;

  // One pixel transaction on its way into the window stage.
  typedef struct packed {
    pos_flags_t         pos;
    logic               cur;   // pixel is transparent
    logic [COORD_W-1:0] x0;    // cx-1
    logic [COORD_W-1:0] x1;    // cx
    logic [COORD_W-1:0] y0;    // cy-1
    logic [COORD_W-1:0] y1;    // cy
  } stage_item_t;

  // Up to four finished pixels; hit bit order is raster order:
  // (x0,y0), (x1,y0), (x0,y1), (x1,y1).
  typedef struct packed {
    logic [3:0]         hit;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
  } res_set_t;

  // Decide one candidate. dc/dr are its column/row offsets from the newest
  // pixel in the window; the window bit for offset (c,r) is win[3*c+r].
  function automatic logic is_border(logic [WIN_W-1:0] win, int dc, int dr,
                                     logic xf, logic xl, logic yf, logic yl);
    logic any;
    logic ok;
    int   i;
    int   j;
    any = 1'b0;
    for (i = -1; i <= 1; i++) begin
      for (j = -1; j <= 1; j++) begin
        ok = 1'b1;
        if (i == -1 && xf) ok = 1'b0;
        if (i == 1 && xl)  ok = 1'b0;
        if (j == -1 && yf) ok = 1'b0;
        if (j == 1 && yl)  ok = 1'b0;
        if (ok) begin
          if (win[3 * (dc - i) + (dr - j)]) any = 1'b1;
        end
      end
    end
    if (win[3 * dc + dr]) begin
      return 1'b0;
    end else if ((xf || xl) && (yf || yl)) begin
      return 1'b1;
    end
    return any;
  endfunction

endpackage

@@ sv/bpd_line_mem.sv @@
// Simple dual-port line memory with registered read data.
module bpd_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bpd_window.sv @@
// Window stage: merge line data, shift the 3x3 window and decide finished pixels.
module bpd_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  bpd_pkg::stage_item_t              load_item,
  input  logic                              load_fwd,
  input  logic [bpd_pkg::LINE_W-1:0]        load_fwd_data,
  input  logic [bpd_pkg::LINE_W-1:0]        rdata,
  input  logic                              advance,
  output logic                              valid,
  output logic [bpd_pkg::LINE_W-1:0]        wr_data,
  output bpd_pkg::res_set_t                 res
);

  bpd_pkg::stage_item_t              item;
  logic                              fwd;
  logic [bpd_pkg::LINE_W-1:0]        fwd_data;
  logic [bpd_pkg::WIN_W-1:0]         win;
  logic [bpd_pkg::WIN_W-1:0]         win_next;
  logic [bpd_pkg::LINE_W-1:0]        line;
  logic [2:0]                        col;
  bpd_pkg::pos_flags_t               p;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      win   <= '0;
    end else begin
      if (load) begin
        valid <= 1'b1;
      end else if (advance) begin
        valid <= 1'b0;
      end
      if (advance) begin
        win <= win_next;
      end
    end
    if (load) begin
      item     <= load_item;
      fwd      <= load_fwd;
      fwd_data <= load_fwd_data;
    end
  end

  always_comb begin
    // Take the value just written by the previous transaction when the read missed it.
    line     = fwd ? fwd_data : rdata;
    col      = {line[1], line[0], item.cur};
    win_next = {win[5:0], col};
    wr_data  = {line[0], item.cur};
    p        = item.pos;

    res.x0 = item.x0;
    res.x1 = item.x1;
    res.y0 = item.y0;
    res.y1 = item.y1;
    res.hit[0] = !p.row_first && !p.col_first &&
                 bpd_pkg::is_border(win_next, 1, 1, p.col_second, 1'b0,
                                    p.row_second, 1'b0);
    res.hit[1] = !p.row_first && p.col_last &&
                 bpd_pkg::is_border(win_next, 0, 1, p.col_first, 1'b1,
                                    p.row_second, 1'b0);
    res.hit[2] = p.row_last && !p.col_first &&
                 bpd_pkg::is_border(win_next, 1, 0, p.col_second, 1'b0,
                                    p.row_first, 1'b1);
    res.hit[3] = p.row_last && p.col_last &&
                 bpd_pkg::is_border(win_next, 0, 0, p.col_first, 1'b1,
                                    p.row_first, 1'b1);
  end

endmodule

@@ sv/bpd_out_queue.sv @@
// Result register: hold up to four finished points and hand them out in raster order.
module bpd_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bpd_pkg::res_set_t    res_in,
  output logic                 load_ok,
  output logic                 pt_valid,
  input  logic                 pt_ready,
  output bpd_pkg::point_t      pt
);

  bpd_pkg::res_set_t held;
  logic [3:0]        mask;
  logic [3:0]        mask_next;
  logic              fire;

  always_comb begin
    mask_next   = mask & (mask - 4'd1);
    pt_valid    = |mask;
    fire        = pt_valid && pt_ready;
    load_ok     = !pt_valid || (fire && mask_next == 4'd0);
    pt.last_of_run = (mask_next == 4'd0);
    if (mask[0]) begin
      pt.point_x = held.x0;
      pt.point_y = held.y0;
    end else if (mask[1]) begin
      pt.point_x = held.x1;
      pt.point_y = held.y0;
    end else if (mask[2]) begin
      pt.point_x = held.x0;
      pt.point_y = held.y1;
    end else begin
      pt.point_x = held.x1;
      pt.point_y = held.y1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (load) begin
      mask <= res_in.hit;
    end else if (fire) begin
      mask <= mask_next;
    end
    if (load) begin
      held <= res_in;
    end
  end

endmodule

@@ sv/border_pixel_detector_3x3_unit.sv @@
// Top level of the 3x3 border pixel detector.
//
// Pixels stream in raster order on the pix channel; a pixel equal to the
// transparent value counts as background. The unit reports, on the pt channel,
// the column and row of every opaque pixel that has background somewhere in
// its 3x3 window (clamped at the image edges), plus every opaque corner. A
// pixel is decided once its clamped lower-right neighbor arrives, so one
// transaction finishes zero to four points; they come out in raster order and
// the final one of each input transaction carries last_of_run. The unit takes
// one pixel per clock: the transaction reads the line memory (flags of the two
// rows above) in the accept cycle, and the window stage writes it back when the
// transaction leaves the stage, forwarding the fresh entry when the next pixel
// hits the same column (one-pixel-wide images or a restart at column 0). The
// output side sends one point per clock while pt_ready is high, so a transaction
// holds the pt channel until its last point is taken, and input backs up only
// while that happens. A point passes the window stage register and then the
// result register before it is offered. The line memory needs no
// clearing after reset: entries are only read for rows that the current frame
// has already written.
// Sizes are the low SIZE_W bits of cfg_wdata; outside 1..MAX_WIDTH / 1..MAX_HEIGHT
// they saturate. frame_start restarts at (0,0); the position also wraps on its own
// after the last pixel. Write configuration only while no transaction is in flight.
module border_pixel_detector_3x3_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  bpd_pkg::pix_t                       pix,
  output logic                                pt_valid,
  input  logic                                pt_ready,
  output bpd_pkg::point_t                     pt,
  input  logic                                cfg_wen,
  input  logic [bpd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WRstLast = ((1024 > MAX_WIDTH) ? MAX_WIDTH : 1024) - 1;
  localparam int HRstLast = ((1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024) - 1;

  // Configuration, kept as saturated last column / last row.
  logic [bpd_pkg::PIXEL_W-1:0] transparent;
  logic [XW-1:0]               w_last;
  logic [YW-1:0]               h_last;
  logic [bpd_pkg::SIZE_W-1:0]  size_raw;

  // Position of the next pixel.
  logic [XW-1:0] col_cnt;
  logic [YW-1:0] row_cnt;
  logic [XW-1:0] col_cnt_next;
  logic [YW-1:0] row_cnt_next;

  logic [XW-1:0] cx_pre;
  logic [YW-1:0] cy_pre;
  logic          col_wrap;
  logic [YW:0]   cy_t;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;

  logic                          accept;
  logic                          advance;
  logic                          load_ok;
  logic                          s1_valid;
  logic [XW-1:0]                 s1_addr;
  logic [bpd_pkg::LINE_W-1:0]    wr_data;
  logic [bpd_pkg::LINE_W-1:0]    rdata;
  logic                          fwd;
  bpd_pkg::stage_item_t          item;
  bpd_pkg::res_set_t             res;

  assign size_raw = cfg_wdata[bpd_pkg::SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      transparent <= '0;
      w_last      <= XW'(WRstLast);
      h_last      <= YW'(HRstLast);
    end else if (cfg_wen) begin
      case (cfg_idx)
        bpd_pkg::CFG_TRANSPARENT: begin
          transparent <= cfg_wdata[bpd_pkg::PIXEL_W-1:0];
        end
        bpd_pkg::CFG_WIDTH: begin
          if (size_raw == '0) begin
            w_last <= '0;
          end else if (32'(size_raw) > 32'(MAX_WIDTH)) begin
            w_last <= XW'(MAX_WIDTH - 1);
          end else begin
            w_last <= XW'(size_raw - bpd_pkg::SIZE_W'(1));
          end
        end
        bpd_pkg::CFG_HEIGHT: begin
          if (size_raw == '0) begin
            h_last <= '0;
          end else if (32'(size_raw) > 32'(MAX_HEIGHT)) begin
            h_last <= YW'(MAX_HEIGHT - 1);
          end else begin
            h_last <= YW'(size_raw - bpd_pkg::SIZE_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Resolve the position of the arriving pixel; a size lowered mid-frame
  // can leave the counters past the edge, so fold them back first.
  always_comb begin
    cx_pre   = pix.frame_start ? '0 : col_cnt;
    cy_pre   = pix.frame_start ? '0 : row_cnt;
    col_wrap = (cx_pre > w_last);
    cx       = col_wrap ? '0 : cx_pre;
    cy_t     = {1'b0, cy_pre} + (YW + 1)'(col_wrap);
    cy       = (cy_t > {1'b0, h_last}) ? '0 : cy_t[YW-1:0];

    if (cx == w_last) begin
      col_cnt_next = '0;
      row_cnt_next = (cy == h_last) ? '0 : cy + YW'(1);
    end else begin
      col_cnt_next = cx + XW'(1);
      row_cnt_next = cy;
    end

    item.pos.col_first  = (cx == '0);
    item.pos.col_second = (cx == XW'(1));
    item.pos.col_last   = (cx == w_last);
    item.pos.row_first  = (cy == '0);
    item.pos.row_second = (cy == YW'(1));
    item.pos.row_last   = (cy == h_last);
    item.cur = (pix.pixel == transparent);
    item.x1  = bpd_pkg::COORD_W'(cx);
    item.x0  = bpd_pkg::COORD_W'(cx - XW'(1));
    item.y1  = bpd_pkg::COORD_W'(cy);
    item.y0  = bpd_pkg::COORD_W'(cy - YW'(1));
  end

  // Stage handshakes: the window stage hands its points to the result
  // register when that register is empty or emptying this cycle.
  assign advance   = s1_valid && load_ok;
  assign pix_ready = !s1_valid || advance;
  assign accept    = pix_valid && pix_ready;
  // The window stage writes back at the same edge this read happens.
  assign fwd       = s1_valid && (s1_addr == cx);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
    end
    if (accept) begin
      s1_addr <= cx;
    end
  end

  bpd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW),
    .DW    (bpd_pkg::LINE_W)
  ) u_line_mem (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (cx),
    .rdata (rdata)
  );

  bpd_window u_window (
    .clk           (clk),
    .rst           (rst),
    .load          (accept),
    .load_item     (item),
    .load_fwd      (fwd),
    .load_fwd_data (wr_data),
    .rdata         (rdata),
    .advance       (advance),
    .valid         (s1_valid),
    .wr_data       (wr_data),
    .res           (res)
  );

  bpd_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res_in   (res),
    .load_ok  (load_ok),
    .pt_valid (pt_valid),
    .pt_ready (pt_ready),
    .pt       (pt)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the 3x3 border pixel detector unit.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int SETTLE_CYCLES  = 8;     // covers the pixel-to-point latency
  localparam int HOLD_CYCLES    = 120;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int RANDOM_ITEMS   = 40;
  localparam int EDGE_RUN       = 16;    // pixels sent into each saturated frame

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           pix_valid = 1'b0;
  logic                           pix_ready;
  bpd_pkg::pix_t                  pix       = '0;
  logic                           pt_valid;
  logic                           pt_ready  = 1'b0;
  bpd_pkg::point_t                pt;
  logic                           cfg_wen   = 1'b0;
  logic [bpd_pkg::CFG_IDX_W-1:0]  cfg_idx   = bpd_pkg::CFG_TRANSPARENT;
  logic [bpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Receiver controls
  logic hold_trigger = 1'b0;
  logic steady_flow  = 1'b0;
  int   hold_left;

  // Sender control
  bit steady_send = 1'b0;

  // Predictor copy of configuration and state
  logic [bpd_pkg::PIXEL_W-1:0] clear_value = '0;
  logic [bpd_pkg::SIZE_W-1:0]  width_reg   = 11'd1024;
  logic [bpd_pkg::SIZE_W-1:0]  height_reg  = 11'd1024;
  bit                          line_up1 [0:MAX_W-1];
  bit                          line_up2 [0:MAX_W-1];
  bit [bpd_pkg::WIN_W-1:0]     window_flags = '0;
  int                          col_pos = 0;
  int                          row_pos = 0;

  bpd_pkg::point_t pending_points [$];
  int              fail_count   = 0;
  int              stuck_cycles = 0;

  border_pixel_detector_3x3_unit #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int size_in_use(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return int'(maxv);
    return int'(v);
  endfunction

  // Transparency flag of pixel (c,r) while (cx,cy) is the newest pixel.
  function automatic bit window_bit(int cx, int cy, int c, int r);
    int sh;
    sh = 3 * (cx - c) + (cy - r);
    return (sh >= 0 && sh < bpd_pkg::WIN_W) ? window_flags[sh] : 1'b0;
  endfunction

  function automatic bit is_edge_point(int cx, int cy, int x, int y, int w, int h);
    int x0, x1, y0, y1, i, j;
    if (window_bit(cx, cy, x, y)) return 1'b0;
    // opaque image corners always count
    if ((x == 0 || x == w - 1) && (y == 0 || y == h - 1)) return 1'b1;
    x0 = (x > 0) ? x - 1 : x;
    x1 = (x < w - 1) ? x + 1 : x;
    y0 = (y > 0) ? y - 1 : y;
    y1 = (y < h - 1) ? y + 1 : y;
    for (i = x0; i <= x1; i++)
      for (j = y0; j <= y1; j++)
        if (window_bit(cx, cy, i, j)) return 1'b1;
    return 1'b0;
  endfunction

  // Advance the position, update the line flags and queue every border point
  // that this pixel finishes, in raster order.
  task automatic predict_points(input bpd_pkg::pix_t item);
    int                          w, h, cx, cy, a, b, n, k, nx, ny;
    int                          xs [2];
    int                          ys [2];
    logic [bpd_pkg::COORD_W-1:0] hit_x [4];
    logic [bpd_pkg::COORD_W-1:0] hit_y [4];
    bit                          cur, above, two;
    bpd_pkg::point_t             p;
    w = size_in_use(width_reg, MAX_W);
    h = size_in_use(height_reg, MAX_H);
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // size lowered mid-frame: fold the position back inside the image
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    cx = col_pos;
    cy = row_pos;

    cur   = (item.pixel == clear_value);
    above = line_up1[cx];
    two   = line_up2[cx];
    line_up2[cx] = above;
    line_up1[cx] = cur;
    window_flags = {window_flags[bpd_pkg::WIN_W-4:0], two, above, cur};

    nx = 0;
    ny = 0;
    if (cy >= 1) ys[ny++] = cy - 1;
    if (cy == h - 1) ys[ny++] = cy;
    if (cx >= 1) xs[nx++] = cx - 1;
    if (cx == w - 1) xs[nx++] = cx;

    n = 0;
    for (a = 0; a < ny; a++)
      for (b = 0; b < nx; b++)
        if (is_edge_point(cx, cy, xs[b], ys[a], w, h)) begin
          hit_x[n] = bpd_pkg::COORD_W'(xs[b]);
          hit_y[n] = bpd_pkg::COORD_W'(ys[a]);
          n++;
        end
    for (k = 0; k < n; k++) begin
      p.point_x     = hit_x[k];
      p.point_y     = hit_y[k];
      p.last_of_run = (k == n - 1);
      pending_points = {pending_points, p};
    end

    col_pos = cx + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = cy + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_point(input bpd_pkg::point_t got);
    bpd_pkg::point_t want;
    if (pending_points.size() == 0) begin
      $display("%0t: unexpected point x=%0d y=%0d last=%0b, nothing pending",
               $time, got.point_x, got.point_y, got.last_of_run);
      fail_count++;
    end else begin
      want = pending_points.pop_front();
      if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
          got.last_of_run !== want.last_of_run) begin
        $display("%0t: point mismatch, expected x=%0d y=%0d last=%0b,",
                 $time, want.point_x, want.point_y, want.last_of_run,
                 " got x=%0d y=%0d last=%0b",
                 got.point_x, got.point_y, got.last_of_run);
        fail_count++;
      end
    end
  endtask

  // Predict before checking so that a same-edge point always finds its entry.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && pix_ready) predict_points(pix);
      if (pt_valid && pt_ready) check_point(pt);
    end
  end

  // Receiver: random stalls, steady stretches and one long counted hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pt_ready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_trigger) begin
      pt_ready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      pt_ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (steady_flow) begin
      pt_ready <= 1'b1;
    end else begin
      pt_ready <= ($urandom_range(99) >= 30);
    end
  end

  // Watchdog: abort when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (pt_valid && pt_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** border_pixel_detector_3x3_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------
  // Offer one pixel and hold it until accepted; valid stays high afterwards.
  task automatic send_pixel(input logic [bpd_pkg::PIXEL_W-1:0] value, input logic fs);
    if (!steady_send) begin
      while ($urandom_range(99) < 30) begin
        pix_valid <= 1'b0;
        @(posedge clk);
      end
    end
    pix_valid <= 1'b1;
    pix       <= {value, fs};
    do @(posedge clk); while (!pix_ready);
  endtask

  // Stop offering, wait for every pending point, then let the pipe settle.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpd_pkg::CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      bpd_pkg::CFG_TRANSPARENT: clear_value = data;
      bpd_pkg::CFG_WIDTH:       width_reg   = data[bpd_pkg::SIZE_W-1:0];
      bpd_pkg::CFG_HEIGHT:      height_reg  = data[bpd_pkg::SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [bpd_pkg::CFG_DATA_W-1:0] clear,
                           input logic [bpd_pkg::CFG_DATA_W-1:0] w,
                           input logic [bpd_pkg::CFG_DATA_W-1:0] h);
    wait_drained();
    write_reg(bpd_pkg::CFG_TRANSPARENT, clear);
    write_reg(bpd_pkg::CFG_WIDTH, w);
    write_reg(bpd_pkg::CFG_HEIGHT, h);
  endtask

  // Background for clear_pct percent of pixels, one bit off background for ten more, random values otherwise.
  function automatic logic [bpd_pkg::PIXEL_W-1:0] pick_pixel(int clear_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < clear_pct) return clear_value;
    if (roll < clear_pct + 10) return clear_value ^ (32'd1 << $urandom_range(31));
    return $urandom();
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Single-pixel image, all-ones background, and a 3x3 frame around a hole.
  task automatic test_corner_cases();
    int i;
    set_frame(32'hFFFF_FFFF, 1, 1);
    send_pixel(32'h0000_0000, 1'b1);   // opaque corner
    send_pixel(32'hFFFF_FFFF, 1'b0);   // background: nothing to report
    send_pixel(32'h1234_5678, 1'b0);   // wraps on its own
    set_frame(32'h0000_0000, 3, 3);
    for (i = 0; i < 9; i++)
      send_pixel((i == 4) ? 32'h0000_0000 : 32'hFFFF_FFFF, i == 0);
  endtask

  // Shrink the size while a frame is open, then restart mid-frame.
  task automatic test_size_changes();
    int i;
    set_frame(32'h0000_00FF, 4, 3);
    for (i = 0; i < 6; i++)
      send_pixel((i == 2 || i == 5) ? 32'h0000_00FF : $urandom(), i == 0);
    // column now past the new width: continue on the next row
    wait_drained();
    write_reg(bpd_pkg::CFG_WIDTH, 32'd2);
    for (i = 0; i < 2; i++)
      send_pixel((i == 0) ? 32'h0000_00FF : $urandom(), 1'b0);
    for (i = 0; i < 3; i++)
      send_pixel((i == 1) ? 32'h0000_00FF : $urandom(), 1'b0);
    // row now past the new height: continue on row 0
    wait_drained();
    write_reg(bpd_pkg::CFG_HEIGHT, 32'd1);
    send_pixel($urandom(), 1'b0);
    send_pixel($urandom(), 1'b0);
    send_pixel(32'h0000_00FF, 1'b1);
  endtask

  // Start of a full-width row and of a full-height column, sizes out of range.
  task automatic test_max_sizes();
    int i;
    set_frame($urandom(), 32'hFFFF_FFFF, 32'hFFFF_F800);   // saturates to 1024 x 1
    for (i = 0; i < EDGE_RUN; i++)
      send_pixel(pick_pixel(25), i == 0);
    set_frame($urandom(), 32'h0000_F800, 32'd1024);        // saturates to 1 x 1024
    for (i = 0; i < EDGE_RUN; i++)
      send_pixel(pick_pixel(25), i == 0);
  endtask

  // Hold the receiver off while a checkerboard floods the unit with points.
  task automatic test_backpressure();
    int n, i;
    set_frame($urandom(), 4, 4);
    steady_send = 1'b1;
    hold_trigger <= 1'b1;
    @(posedge clk);
    hold_trigger <= 1'b0;
    for (n = 0; n < 2; n++)
      for (i = 0; i < 16; i++)
        send_pixel(((i / 4 + i % 4) % 2 != 0) ? clear_value
                                              : clear_value ^ $urandom_range(255, 1),
                   i == 0);
    steady_send = 1'b0;
    wait_drained();   // sender pauses until every point has come
  endtask

  // Neither side idles.
  task automatic test_back_to_back();
    int n, i;
    set_frame($urandom(), 5, 4);
    steady_send = 1'b1;
    steady_flow <= 1'b1;
    for (n = 0; n < 2; n++)
      for (i = 0; i < 20; i++)
        send_pixel(pick_pixel(40), i == 0);
    steady_send = 1'b0;
    steady_flow <= 1'b0;
  endtask

  // Small random frames; a few cut short or restarted partway.
  task automatic test_random_frames();
    int sent, w, h, pct, stop_at, k;
    logic [bpd_pkg::PIXEL_W-1:0] clear;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = ($urandom_range(99) < 15) ? 1 : $urandom_range(8, 2);
      h = ($urandom_range(99) < 15) ? 1 : $urandom_range(6, 2);
      case ($urandom_range(3))
        0:       clear = 32'h0000_0000;
        1:       clear = 32'hFFFF_FFFF;
        default: clear = $urandom();
      endcase
      pct = $urandom_range(70, 5);
      set_frame(clear, w, h);
      stop_at = w * h;
      if (stop_at > 1 && $urandom_range(99) < 10) stop_at = $urandom_range(stop_at - 1, 1);
      for (k = 0; k < stop_at; k++)
        send_pixel(pick_pixel(pct), (k == 0) || ($urandom_range(99) < 3));
      sent += stop_at;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_size_changes();
    test_max_sizes();
    test_backpressure();
    test_back_to_back();
    test_random_frames();
    wait_drained();
    if (fail_count == 0) begin
      $display("** border_pixel_detector_3x3_unit: PASSED **");
    end else begin
      $display("** border_pixel_detector_3x3_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bpd_pkg.sv
sv/bpd_line_mem.sv
sv/bpd_window.sv
sv/bpd_out_queue.sv
sv/border_pixel_detector_3x3_unit.sv
tb/sv/testbench.sv
